>>> rtl/core/quoted_printable_encoder_assert.svh
// Assertion macros for the quoted-printable encoder.
// Used by the top level; expects i_clk and i_rst_n in the including scope.
`ifndef QUOTED_PRINTABLE_ENCODER_ASSERT_SVH
`define QUOTED_PRINTABLE_ENCODER_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define QPE_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define QPE_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

>>> rtl/core/qpe_pkg.sv
// Shared types, constants and functions for the quoted-printable encoder.
// No dependencies; all other files refer to it by scoped names.
package qpe_pkg;

    // Character codes used by the encoder.
    localparam logic [7:0] CH_EQ   = 8'h3D;
    localparam logic [7:0] CH_CR   = 8'h0D;
    localparam logic [7:0] CH_LF   = 8'h0A;
    localparam logic [7:0] CH_DOT  = 8'h2E;
    localparam logic [7:0] PASS_LO_A = 8'd33;
    localparam logic [7:0] PASS_HI_A = 8'd60;
    localparam logic [7:0] PASS_LO_B = 8'd62;
    localparam logic [7:0] PASS_HI_B = 8'd126;

    // Reset value of the maximum line length register.
    localparam logic [7:0] MAX_LINE_LEN_RST = 8'd73;

    // Descriptor queue geometry; the depth must be a power of two.
    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    // Positions within the soft break sequence.
    localparam logic [2:0] BRK_EQ = 3'd0;
    localparam logic [2:0] BRK_CR = 3'd1;
    localparam logic [2:0] BRK_LF = 3'd2;

    // One classified input byte, as handed from front to back.
    typedef struct packed {
        logic [7:0] data_byte;
        logic       esc;
        logic       brk;
        logic       last;
    } t_desc;

    // Write side of the descriptor queue.
    typedef struct packed {
        logic  push;
        t_desc desc;
    } t_push;

    // Read side of the descriptor queue.
    typedef struct packed {
        logic  valid;
        t_desc desc;
    } t_head;

    // True for a byte that is sent as itself.
    function automatic logic passes_through(input logic [7:0] b);
        logic in_range;
        in_range = ((b >= PASS_LO_A) && (b <= PASS_HI_A)) ||
                   ((b >= PASS_LO_B) && (b <= PASS_HI_B));
        return in_range && (b != CH_DOT);
    endfunction

    // Upper-case hex character for one nibble.
    function automatic logic [7:0] hex_digit(input logic [3:0] v);
        logic [7:0] r;
        if (v < 4'd10) begin
            r = 8'h30 + {4'd0, v};
        end else begin
            r = 8'h41 + {4'd0, v} - 8'd10;
        end
        return r;
    endfunction

endpackage

>>> rtl/core/qpe_front.sv
// Front end of the quoted-printable encoder: accepts and classifies bytes.
// Holds the line count and the maximum line length register; uses qpe_pkg.
module qpe_front (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic [7:0]        i_data_byte,
    input  logic              i_message_last,
    input  logic              i_cfg_valid,
    input  logic [7:0]        i_cfg_max_line_len,
    input  logic              i_queue_full,
    output logic              o_in_stall,
    output qpe_pkg::t_push    o_push
);

    logic [7:0] r_line_count;
    logic [7:0] n_line_count;
    logic [7:0] r_max_line_len;
    logic       accept;
    logic       pass;
    logic [9:0] count_new;
    logic       brk;

    // The queue alone can hold back the input.
    assign o_in_stall = i_queue_full;
    assign accept     = i_in_valid && !i_queue_full;

    // Classify the byte and work out the line count after it.
    always_comb begin
        pass      = qpe_pkg::passes_through(i_data_byte);
        count_new = {2'd0, r_line_count} + (pass ? 10'd1 : 10'd3);
        // Compare count >= max - 3 as count + 3 >= max to stay unsigned.
        brk       = (count_new + 10'd3) >= {2'd0, r_max_line_len};
        if (brk || i_message_last) begin
            n_line_count = 8'd0;
        end else begin
            n_line_count = count_new[7:0];
        end
    end

    // Descriptor pushed into the queue.
    always_comb begin
        o_push.push           = accept;
        o_push.desc.data_byte = i_data_byte;
        o_push.desc.esc       = !pass;
        o_push.desc.brk       = brk;
        o_push.desc.last      = i_message_last;
    end

    // Line count and configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_line_count   <= 8'd0;
            r_max_line_len <= qpe_pkg::MAX_LINE_LEN_RST;
        end else begin
            if (accept) begin
                r_line_count <= n_line_count;
            end
            if (i_cfg_valid) begin
                r_max_line_len <= i_cfg_max_line_len;
            end
        end
    end

endmodule

>>> rtl/core/qpe_queue.sv
// Short descriptor queue between the front and back of the encoder.
// Register-based FIFO of qpe_pkg::t_desc entries; uses qpe_pkg.
module qpe_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qpe_pkg::t_push    i_push,
    input  logic              i_pop,
    output logic              o_full,
    output qpe_pkg::t_head    o_head
);

    qpe_pkg::t_desc                 r_mem [qpe_pkg::QUEUE_DEPTH];
    logic [qpe_pkg::QUEUE_AW-1:0]   r_wr_ptr;
    logic [qpe_pkg::QUEUE_AW-1:0]   r_rd_ptr;
    logic [qpe_pkg::QUEUE_CW-1:0]   r_count;

    assign o_full       = (r_count == qpe_pkg::QUEUE_CW'(qpe_pkg::QUEUE_DEPTH));
    assign o_head.valid = (r_count != '0);
    assign o_head.desc  = r_mem[r_rd_ptr];

    // Entry storage.
    always_ff @(posedge i_clk) begin
        if (i_push.push) begin
            r_mem[r_wr_ptr] <= i_push.desc;
        end
    end

    // Pointers wrap naturally since the depth is a power of two.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push.push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_push.push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

endmodule

>>> rtl/core/qpe_back.sv
// Quoted-printable back end: emits one output word per cycle unless stalled.
// Walks the characters of the queue head into an output register; uses qpe_pkg.
module qpe_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  qpe_pkg::t_head    i_head,
    output logic              o_pop,
    input  logic              i_out_stall,
    output logic              o_out_valid,
    output logic [7:0]        o_out_byte,
    output logic              o_run_last,
    output logic              o_message_end
);

    logic [2:0] r_idx;
    logic       r_valid;
    logic [7:0] r_byte;
    logic       r_run_last;
    logic       r_msg_end;
    logic       load_en;
    logic       step;
    logic [2:0] last_idx;
    logic       final_one;
    logic       in_break;
    logic [2:0] brk_pos;
    logic [7:0] brk_char;
    logic [7:0] n_byte;

    // The output register takes a new word when empty or being drained.
    assign load_en   = !r_valid || !i_out_stall;
    assign step      = load_en && i_head.valid;
    assign last_idx  = (i_head.desc.esc ? 3'd2 : 3'd0) + (i_head.desc.brk ? 3'd3 : 3'd0);
    assign final_one = (r_idx == last_idx);
    assign o_pop     = step && final_one;

    // Pick the character at the current position.
    always_comb begin
        in_break = i_head.desc.esc ? (r_idx >= 3'd3) : (r_idx >= 3'd1);
        brk_pos  = i_head.desc.esc ? (r_idx - 3'd3) : (r_idx - 3'd1);
        case (brk_pos)
            qpe_pkg::BRK_EQ: brk_char = qpe_pkg::CH_EQ;
            qpe_pkg::BRK_CR: brk_char = qpe_pkg::CH_CR;
            qpe_pkg::BRK_LF: brk_char = qpe_pkg::CH_LF;
            default:         brk_char = qpe_pkg::CH_LF;
        endcase
        if (in_break) begin
            n_byte = brk_char;
        end else if (!i_head.desc.esc) begin
            n_byte = i_head.desc.data_byte;
        end else begin
            case (r_idx)
                3'd0:    n_byte = qpe_pkg::CH_EQ;
                3'd1:    n_byte = qpe_pkg::hex_digit(i_head.desc.data_byte[7:4]);
                default: n_byte = qpe_pkg::hex_digit(i_head.desc.data_byte[3:0]);
            endcase
        end
    end

    // Character position within the current item.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx <= 3'd0;
        end else if (step) begin
            r_idx <= final_one ? 3'd0 : r_idx + 3'd1;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (load_en) begin
            r_valid <= i_head.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step) begin
            r_byte     <= n_byte;
            r_run_last <= final_one;
            r_msg_end  <= final_one && i_head.desc.last;
        end
    end

    assign o_out_valid   = r_valid;
    assign o_out_byte    = r_byte;
    assign o_run_last    = r_run_last;
    assign o_message_end = r_msg_end;

endmodule

>>> rtl/core/quoted_printable_encoder.sv
// Quoted-printable encoder. An accepted byte passes through a 4-entry
// descriptor queue and the single output register. A byte yields 1 to 6
// output words (1 or 3 encoded characters plus 3 for a soft break), one word
// per cycle while the output is not stalled; the queue lets input run ahead.
// Reset (synchronous, active low) empties the queue, clears the line count
// and loads 73 into the maximum line length register.
module quoted_printable_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    output logic       o_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_message_last,
    output logic       o_out_valid,
    input  logic       i_out_stall,
    output logic [7:0] o_out_byte,
    output logic       o_run_last,
    output logic       o_message_end,
    input  logic       i_cfg_valid,
    output logic       o_cfg_ready,
    input  logic [7:0] i_cfg_max_line_len
);

    `include "quoted_printable_encoder_assert.svh"

    qpe_pkg::t_push push;
    qpe_pkg::t_head head;
    logic           queue_full;
    logic           pop;

    // The configuration register accepts a word in any cycle.
    assign o_cfg_ready = 1'b1;

    // Front end: classification and line counting.
    qpe_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .i_data_byte        (i_data_byte),
        .i_message_last     (i_message_last),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_max_line_len (i_cfg_max_line_len),
        .i_queue_full       (queue_full),
        .o_in_stall         (o_in_stall),
        .o_push             (push)
    );

    // Descriptor queue.
    qpe_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_pop   (pop),
        .o_full  (queue_full),
        .o_head  (head)
    );

    // Back end: character sequencing and output register.
    qpe_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_head        (head),
        .o_pop         (pop),
        .i_out_stall   (i_out_stall),
        .o_out_valid   (o_out_valid),
        .o_out_byte    (o_out_byte),
        .o_run_last    (o_run_last),
        .o_message_end (o_message_end)
    );

    // A raw line feed only ever closes a soft break, so it ends its run.
    `QPE_ASSERT_SAME(a_lf_ends_run, o_out_valid && (o_out_byte == qpe_pkg::CH_LF), o_run_last, "line feed not at end of run")

    // A carriage return that leaves is followed at once by the line feed.
    `QPE_ASSERT_NEXT(a_cr_then_lf, o_out_valid && !i_out_stall && (o_out_byte == qpe_pkg::CH_CR), o_out_valid && (o_out_byte == qpe_pkg::CH_LF), "carriage return not followed by line feed")

    // The end of a message is always the end of a run.
    `QPE_ASSERT_SAME(a_msg_end_run, o_out_valid && o_message_end, o_run_last, "message end off run end")

    // The front never pushes into a full queue.
    `QPE_ASSERT_SAME(a_no_overflow, push.push, !queue_full, "push into full queue")

endmodule

>>> test/qpe_checker.sv
// Scoreboard for the quoted-printable encoder: watches the byte, result and setup channels.
// Predicts the encoded characters per accepted byte and compares them in order.
// Depends on qpe_pkg for the character codes and the reset line length.
module qpe_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_message_last,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [7:0] i_out_byte,
    input  logic       i_run_last,
    input  logic       i_message_end,
    input  logic       i_cfg_valid,
    input  logic       i_cfg_ready,
    input  logic [7:0] i_cfg_max_line_len,
    output int         o_fail_count,
    output int         o_pending,
    output int         o_words_checked
);

    // One encoded character together with its two markers.
    typedef struct packed {
        logic [7:0] ch;
        logic       run_last;
        logic       msg_end;
    } t_enc_word;

    t_enc_word  encoded_fifo[$];
    logic [7:0] line_len_limit = qpe_pkg::MAX_LINE_LEN_RST;
    logic [7:0] chars_on_line  = 8'd0;

    // Upper-case hex character for one nibble.
    function automatic logic [7:0] nibble_char(input logic [3:0] v);
        if (v < 4'd10) begin
            return 8'd48 + {4'd0, v};
        end
        return 8'd55 + {4'd0, v};
    endfunction

    // Encode one raw byte, queue its characters and advance the line count.
    function automatic void encode_byte(input logic [7:0] b, input logic last);
        logic [7:0] chars [0:5];
        int         n;
        int         cnt;
        int         k;
        t_enc_word  w;
        n   = 0;
        cnt = int'(chars_on_line);
        if (((b >= 8'd33 && b <= 8'd60) || (b >= 8'd62 && b <= 8'd126)) &&
            b != qpe_pkg::CH_DOT) begin
            chars[0] = b;
            n        = 1;
            cnt      = cnt + 1;
        end else begin
            chars[0] = qpe_pkg::CH_EQ;
            chars[1] = nibble_char(b[7:4]);
            chars[2] = nibble_char(b[3:0]);
            n        = 3;
            cnt      = cnt + 3;
        end
        // A soft break follows once the line reaches the limit minus three.
        if (cnt >= int'(line_len_limit) - 3) begin
            chars[n]     = qpe_pkg::CH_EQ;
            chars[n + 1] = qpe_pkg::CH_CR;
            chars[n + 2] = qpe_pkg::CH_LF;
            n            = n + 3;
            cnt          = 0;
        end
        if (last) begin
            cnt = 0;
        end
        chars_on_line = cnt[7:0];
        for (k = 0; k < n; k++) begin
            w.ch       = chars[k];
            w.run_last = (k == n - 1);
            w.msg_end  = (k == n - 1) && last;
            encoded_fifo.insert(encoded_fifo.size(), w);
        end
    endfunction

    // Report one field mismatch.
    function automatic void report_field(input string field, input logic [7:0] want,
                                         input logic [7:0] got);
        o_fail_count = o_fail_count + 1;
        $display("%0t: %s mismatch, expected %02h, actual %02h", $time, field, want, got);
    endfunction

    // Results are checked before new bytes are predicted; a byte never shows up
    // on the output in the cycle it is accepted.
    always @(posedge i_clk) begin
        t_enc_word want;
        if (!i_rst_n) begin
            encoded_fifo.delete();
            line_len_limit = qpe_pkg::MAX_LINE_LEN_RST;
            chars_on_line  = 8'd0;
        end else begin
            if (i_out_valid && !i_out_stall) begin
                o_words_checked = o_words_checked + 1;
                if (encoded_fifo.size() == 0) begin
                    o_fail_count = o_fail_count + 1;
                    $display("%0t: unexpected output word, expected none, actual %02h",
                             $time, i_out_byte);
                end else begin
                    want = encoded_fifo.pop_front();
                    if (i_out_byte !== want.ch) begin
                        report_field("out_byte", want.ch, i_out_byte);
                    end
                    if (i_run_last !== want.run_last) begin
                        report_field("run_last", {7'd0, want.run_last}, {7'd0, i_run_last});
                    end
                    if (i_message_end !== want.msg_end) begin
                        report_field("message_end", {7'd0, want.msg_end},
                                     {7'd0, i_message_end});
                    end
                end
            end
            if (i_cfg_valid && i_cfg_ready) begin
                line_len_limit = i_cfg_max_line_len;
            end
            if (i_in_valid && !i_in_stall) begin
                encode_byte(i_data_byte, i_message_last);
            end
        end
        o_pending = encoded_fifo.size();
    end

endmodule

>>> test/tb_quoted_printable_encoder.sv
// Top of the quoted-printable encoder testbench: clock, reset, stimulus and verdict.
// Depends on qpe_pkg, quoted_printable_encoder and the qpe_checker scoreboard.
module tb_quoted_printable_encoder;

    logic       clk            = 1'b0;
    logic       rst_n          = 1'b0;
    logic       in_valid       = 1'b0;
    logic [7:0] data_byte      = 8'd0;
    logic       message_last   = 1'b0;
    logic       out_stall      = 1'b0;
    logic       cfg_valid      = 1'b0;
    logic [7:0] cfg_max_len    = 8'd0;
    logic       in_stall;
    logic       out_valid;
    logic [7:0] out_byte;
    logic       run_last;
    logic       message_end;
    logic       cfg_ready;
    int         fail_count;
    int         pending;
    int         words_checked;

    // Sender and receiver idle rates in percent, and the long hold-off request.
    int         send_idle_pct  = 10;
    int         recv_idle_pct  = 56;
    logic       hold_toggle    = 1'b0;
    logic       hold_seen      = 1'b0;
    int         hold_left      = 0;
    int         bytes_sent     = 0;

    // Directed bytes as {message_last, data_byte}.
    logic [8:0] directed_words [0:22] = '{
        9'h000, 9'h1FF, 9'h020, 9'h021, 9'h03C, 9'h03D, 9'h03E, 9'h07E,
        9'h07F, 9'h02E, 9'h00D, 9'h180,
        9'h041, 9'h12E,
        9'h041, 9'h042, 9'h043, 9'h03D, 9'h044, 9'h045, 9'h120, 9'h001, 9'h102
    };

    quoted_printable_encoder u_dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_stall         (in_stall),
        .i_data_byte        (data_byte),
        .i_message_last     (message_last),
        .o_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .o_out_byte         (out_byte),
        .o_run_last         (run_last),
        .o_message_end      (message_end),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (cfg_ready),
        .i_cfg_max_line_len (cfg_max_len)
    );

    qpe_checker u_checker (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .i_in_stall         (in_stall),
        .i_data_byte        (data_byte),
        .i_message_last     (message_last),
        .i_out_valid        (out_valid),
        .i_out_stall        (out_stall),
        .i_out_byte         (out_byte),
        .i_run_last         (run_last),
        .i_message_end      (message_end),
        .i_cfg_valid        (cfg_valid),
        .i_cfg_ready        (cfg_ready),
        .i_cfg_max_line_len (cfg_max_len),
        .o_fail_count       (fail_count),
        .o_pending          (pending),
        .o_words_checked    (words_checked)
    );

    // Free-running clock, period 10.
    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Receiver stall: a long counted hold-off when requested, otherwise random idling.
    always @(posedge clk) begin
        if (hold_left > 0) begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end else if (hold_toggle != hold_seen) begin
            hold_seen <= hold_toggle;
            hold_left <= 80;
            out_stall <= 1'b1;
        end else begin
            out_stall <= ($urandom_range(0, 99) < recv_idle_pct);
        end
    end

    // Offer one byte, idling first at the sender's rate, and wait for acceptance.
    task automatic send_byte(input logic [7:0] b, input logic last);
        while ($urandom_range(0, 99) < send_idle_pct) begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid     <= 1'b1;
        data_byte    <= b;
        message_last <= last;
        @(posedge clk);
        while (in_stall) begin
            @(posedge clk);
        end
        bytes_sent = bytes_sent + 1;
    endtask

    // Stop offering and wait, with a limit, until every predicted word has come out.
    task automatic drain_output();
        int waited;
        waited = 0;
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && waited < 50000) begin
            @(posedge clk);
            waited++;
        end
    endtask

    // Change the maximum line length while the encoder is idle.
    task automatic write_max_len(input logic [7:0] v);
        drain_output();
        repeat (4) @(posedge clk);
        cfg_valid   <= 1'b1;
        cfg_max_len <= v;
        @(posedge clk);
        while (!cfg_ready) begin
            @(posedge clk);
        end
        cfg_valid <= 1'b0;
    endtask

    // Random byte: mostly literal characters, full-range bytes and the escaped specials.
    task automatic send_random();
        logic [7:0] b;
        int         pick;
        pick = $urandom_range(0, 9);
        if (pick < 4) begin
            b = 8'($urandom_range(33, 126));
        end else if (pick < 8) begin
            b = 8'($urandom_range(0, 255));
        end else begin
            case ($urandom_range(0, 4))
                0: b = 8'h20;
                1: b = qpe_pkg::CH_EQ;
                2: b = qpe_pkg::CH_DOT;
                3: b = qpe_pkg::CH_CR;
                default: b = qpe_pkg::CH_LF;
            endcase
        end
        send_byte(b, $urandom_range(0, 11) == 0);
    endtask

    // Stimulus: directed bytes over three settings, then six random phases.
    initial begin
        logic [7:0] seg_limit [0:5];
        int         i;
        int         s;
        int         r;
        seg_limit[0] = 8'd255;
        seg_limit[1] = 8'd0;
        seg_limit[2] = 8'($urandom_range(4, 60));
        seg_limit[3] = 8'd2;
        seg_limit[4] = 8'($urandom_range(61, 254));
        seg_limit[5] = 8'd3;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Field extremes and every character class at the reset line length.
        for (i = 0; i < 12; i++) begin
            send_byte(directed_words[i][7:0], directed_words[i][8]);
        end
        // Limit below three: every byte is followed by a soft break.
        write_max_len(8'd0);
        for (i = 12; i < 14; i++) begin
            send_byte(directed_words[i][7:0], directed_words[i][8]);
        end
        // Short lines, including a soft break on the last byte of a message.
        write_max_len(8'd9);
        for (i = 14; i < 23; i++) begin
            send_byte(directed_words[i][7:0], directed_words[i][8]);
        end

        r = 0;
        for (s = 0; s < 6; s++) begin
            write_max_len(seg_limit[s]);
            for (i = 0; i < 50; i++) begin
                send_idle_pct = (r < 100) ? 10 : (r < 200) ? 56 : 0;
                recv_idle_pct = (r < 100) ? 56 : (r < 200) ? 10 : 0;
                if (r == 60) begin
                    hold_toggle <= ~hold_toggle;
                end
                if (r == 250) begin
                    drain_output();
                end
                send_random();
                r++;
            end
        end

        drain_output();
        repeat (12) @(posedge clk);
        if (pending != 0) begin
            $display("%0t: %0d predicted words never arrived", $time, pending);
        end
        $display("Covered %0d input words and %0d output words over line limits 73, 0, 9,",
                 bytes_sent, words_checked);
        $display("  255, 0, %0d, 2, %0d and 3, with a long output hold-off and a full drain.",
                 seg_limit[2], seg_limit[4]);
        if (fail_count == 0 && pending == 0) begin
            $display("quoted_printable_encoder verification clean");
        end else begin
            $display("quoted_printable_encoder verification failed");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin
        #3000000;
        $display("quoted_printable_encoder verification failed");
        $finish;
    end

endmodule
